// ----- design/tbnp_pkg.sv -----
`timescale 1ns / 1ps

package tbnp_pkg;

    localparam int unsigned WORD_W = 32;

    localparam logic [7:0] CH_PIPE    = 8'h7C;  // '|'
    localparam logic [7:0] CH_AMP     = 8'h26;  // '&'
    localparam logic [7:0] CH_PLUS    = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS   = 8'h2D;  // '-'
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    // weight of 'a'; 'a'..'f' fit in the word, later lower-case letters add nothing
    localparam logic [WORD_W-1:0] LOWER_BASE = 32'd67108864;
    localparam logic [7:0]        LOWER_FIT  = 8'd6;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_TERM    = 3'd1,
        PH_SIGN    = 3'd2,
        PH_LETTERS = 3'd3,
        PH_DIGITS  = 3'd4
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic                term_negative;
        logic [WORD_W-1:0]   term_value;
        logic [WORD_W-1:0]   chain_sum;
        logic [WORD_W-1:0]   low_word;
        logic                in_high_word;
        logic                letters_allowed_now;
    } t_state;

    typedef struct packed {
        logic [2*WORD_W-1:0] value;
        logic                status;
        logic [7:0]          terminator;
        logic                high_word_present;
    } t_result;

    localparam t_state ST_IDLE = '{
        phase:               PH_IDLE,
        term_negative:       1'b0,
        term_value:          '0,
        chain_sum:           '0,
        low_word:            '0,
        in_high_word:        1'b0,
        letters_allowed_now: 1'b0
    };

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return is_upper(c) || is_lower(c);
    endfunction

    function automatic logic [WORD_W-1:0] digit_val(input logic [7:0] c);
        logic [7:0] d;
        d = c - CH_ZERO;
        return {{(WORD_W-8){1'b0}}, d};
    endfunction

    function automatic logic [WORD_W-1:0] letter_weight(input logic [7:0] c);
        logic [7:0]        sh;
        logic [WORD_W-1:0] w;
        sh = 8'd0;
        w  = '0;
        if (is_upper(c)) begin
            sh = c - CH_UPPER_A;
            w  = {{(WORD_W-1){1'b0}}, 1'b1} << sh[4:0];
        end else if (is_lower(c)) begin
            sh = c - CH_LOWER_A;
            if (sh < LOWER_FIT) begin
                w = LOWER_BASE << sh[2:0];
            end
        end
        return w;
    endfunction

endpackage

// ----- design/tbnp_char_if.sv -----
`timescale 1ns / 1ps

interface tbnp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

// ----- design/tbnp_res_if.sv -----
`timescale 1ns / 1ps

interface tbnp_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic        status;
    logic [7:0]  terminator;
    logic        high_word_present;

    modport source (output valid, output value, output status, output terminator,
                    output high_word_present, input ready);
    modport sink   (input valid, input value, input status, input terminator,
                    input high_word_present, output ready);
endinterface

// ----- design/tbnp_cfg_if.sv -----
`timescale 1ns / 1ps

interface tbnp_cfg_if;
    logic valid;
    logic ready;
    logic flag_letters_enabled;

    modport source (output valid, output flag_letters_enabled, input ready);
    modport sink   (input valid, input flag_letters_enabled, output ready);
endinterface

// ----- design/text_bitvector_number_parser.sv -----
`timescale 1ns / 1ps
// A token's result passes from the input register through the step logic into the result register.
// Throughput: one character per cycle unless a held result blocks stage two; the parser state is
// updated by a single registered step between the input register and the result register.
// Reset (i_rst_n low, synchronous): parser idle, pipeline empty, flag letters disabled.
module text_bitvector_number_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tbnp_cfg_if.sink     i_cfg,
    tbnp_char_if.sink    i_char,
    tbnp_res_if.source   o_res
);

    logic              r_flag;
    logic              r_in_valid;
    logic [7:0]        r_char;
    tbnp_pkg::t_state  r_state;
    logic              r_out_valid;
    tbnp_pkg::t_result r_res;

    tbnp_pkg::t_state  n_state;
    tbnp_pkg::t_result n_res;
    logic              step_emit;
    logic              adv;

    // stage two moves when the result register is free or being drained
    assign adv          = !r_out_valid || o_res.ready;
    assign i_char.ready = !r_in_valid || adv;
    assign i_cfg.ready  = 1'b1;

    tbnp_step u_step (
        .i_state  (r_state),
        .i_char   (r_char),
        .i_flag   (r_flag),
        .o_state  (n_state),
        .o_emit   (step_emit),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag      <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= tbnp_pkg::ST_IDLE;
        end else begin
            if (i_cfg.valid) begin
                r_flag <= i_cfg.flag_letters_enabled;
            end
            if (i_char.ready) begin
                r_in_valid <= i_char.valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid && step_emit;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_char <= i_char.char_in;
        end
        if (adv && r_in_valid && step_emit) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.value             = r_res.value;
    assign o_res.status            = r_res.status;
    assign o_res.terminator        = r_res.terminator;
    assign o_res.high_word_present = r_res.high_word_present;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.status |-> (r_res.value == 64'd0) && !r_res.high_word_present)
        else $error("error beat carries a value");

    a_no_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.high_word_present |-> (r_res.value[63:32] == 32'd0))
        else $error("high word set without a second number");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == tbnp_pkg::PH_IDLE |-> !r_state.in_high_word &&
            (r_state.chain_sum == 32'd0) && (r_state.low_word == 32'd0))
        else $error("idle parser holds partial token");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_char.ready |-> r_in_valid && r_out_valid && !o_res.ready)
        else $error("input stalled without a blocked result");

endmodule

// ----- design/tbnp_step.sv -----
`timescale 1ns / 1ps

// One character's worth of parser update: next state and an optional result.
module tbnp_step (
    input  tbnp_pkg::t_state  i_state,
    input  logic [7:0]        i_char,
    input  logic              i_flag,
    output tbnp_pkg::t_state  o_state,
    output logic              o_emit,
    output tbnp_pkg::t_result o_result
);

    tbnp_pkg::t_state  cur;
    tbnp_pkg::t_state  nx;
    tbnp_pkg::t_result res;
    logic              emit;
    logic              body;
    logic              finish;
    logic              err;
    logic [31:0]       num;
    logic [31:0]       sum;
    logic [31:0]       dig;
    logic [31:0]       wgt;
    logic              c_ws;
    logic              c_dig;
    logic              c_let;
    logic              c_sign;

    always_comb begin
        c_ws   = tbnp_pkg::is_ws(i_char);
        c_dig  = tbnp_pkg::is_digit(i_char);
        c_let  = tbnp_pkg::is_letter(i_char);
        c_sign = (i_char == tbnp_pkg::CH_PLUS) || (i_char == tbnp_pkg::CH_MINUS);
        dig    = tbnp_pkg::digit_val(i_char);
        wgt    = tbnp_pkg::letter_weight(i_char);

        // unknown phase codes behave as a fresh idle parser
        cur = i_state;
        case (i_state.phase)
            tbnp_pkg::PH_IDLE, tbnp_pkg::PH_TERM, tbnp_pkg::PH_SIGN,
            tbnp_pkg::PH_LETTERS, tbnp_pkg::PH_DIGITS: cur = i_state;
            default: cur = tbnp_pkg::ST_IDLE;
        endcase

        nx     = cur;
        emit   = 1'b0;
        body   = 1'b0;
        finish = 1'b0;
        err    = 1'b0;
        num    = '0;
        sum    = '0;
        res    = '0;
        res.terminator = i_char;

        case (cur.phase)
            tbnp_pkg::PH_IDLE, tbnp_pkg::PH_TERM: begin
                if (!c_ws) begin
                    if (cur.phase == tbnp_pkg::PH_IDLE) begin
                        nx = tbnp_pkg::ST_IDLE;
                        nx.letters_allowed_now = i_flag;
                    end
                    nx.term_negative = 1'b0;
                    nx.term_value    = '0;
                    if (c_sign) begin
                        nx.term_negative = (i_char == tbnp_pkg::CH_MINUS);
                        nx.phase         = tbnp_pkg::PH_SIGN;
                    end else begin
                        body = 1'b1;
                    end
                end
            end
            tbnp_pkg::PH_SIGN: begin
                body = 1'b1;
            end
            tbnp_pkg::PH_LETTERS: begin
                if (c_let) begin
                    nx.term_value = cur.term_value + wgt;
                end else if (c_dig) begin
                    nx.term_value = (cur.term_value << 3) + (cur.term_value << 1) + dig;
                    nx.phase      = tbnp_pkg::PH_DIGITS;
                end else begin
                    finish = 1'b1;
                end
            end
            tbnp_pkg::PH_DIGITS: begin
                if (c_dig) begin
                    nx.term_value = (cur.term_value << 3) + (cur.term_value << 1) + dig;
                end else begin
                    finish = 1'b1;
                end
            end
            default: begin
                nx = tbnp_pkg::ST_IDLE;
            end
        endcase

        if (body) begin
            if (c_dig) begin
                nx.term_value = dig;
                nx.phase      = tbnp_pkg::PH_DIGITS;
            end else if (nx.letters_allowed_now && c_let) begin
                nx.term_value = wgt;
                nx.phase      = tbnp_pkg::PH_LETTERS;
            end else if (nx.letters_allowed_now) begin
                finish = 1'b1;
            end else begin
                err = 1'b1;
            end
        end

        if (finish) begin
            num = nx.term_negative ? (32'd0 - nx.term_value) : nx.term_value;
            sum = nx.chain_sum + num;
            nx.term_negative = 1'b0;
            nx.term_value    = '0;
            nx.chain_sum     = sum;
            if (i_char == tbnp_pkg::CH_PIPE) begin
                nx.letters_allowed_now = 1'b0;
                nx.phase               = tbnp_pkg::PH_TERM;
            end else if (!nx.in_high_word && i_char == tbnp_pkg::CH_AMP) begin
                nx.low_word            = sum;
                nx.chain_sum           = '0;
                nx.in_high_word        = 1'b1;
                nx.letters_allowed_now = i_flag;
                nx.phase               = tbnp_pkg::PH_TERM;
            end else begin
                emit = 1'b1;
                res.value = nx.in_high_word ? {sum, nx.low_word} : {32'd0, sum};
                res.high_word_present = nx.in_high_word;
                nx = tbnp_pkg::ST_IDLE;
                // terminator that can open a token starts the next one
                if (c_sign || c_dig || (c_let && i_flag)) begin
                    nx.letters_allowed_now = i_flag;
                    if (c_sign) begin
                        nx.term_negative = (i_char == tbnp_pkg::CH_MINUS);
                        nx.phase         = tbnp_pkg::PH_SIGN;
                    end else if (c_dig) begin
                        nx.term_value = dig;
                        nx.phase      = tbnp_pkg::PH_DIGITS;
                    end else begin
                        nx.term_value = wgt;
                        nx.phase      = tbnp_pkg::PH_LETTERS;
                    end
                end
            end
        end

        if (err) begin
            emit       = 1'b1;
            res.status = 1'b1;
            nx         = tbnp_pkg::ST_IDLE;
        end
    end

    assign o_state  = nx;
    assign o_emit   = emit;
    assign o_result = res;

endmodule
